// ===== rtl/gai_pkg.sv =====
// Shared widths, constants, sequencer codes and lane control types of the gyro angle integrator.
package gai_pkg;

  localparam int RAW_W  = 16;   // raw gyro sample
  localparam int TICK_W = 16;   // elapsed timer ticks
  localparam int FS_W   = 11;   // full scale, deg/s
  localparam int DB_W   = 8;    // deadband, whole deg/s
  localparam int TP_W   = 32;   // tick period, Q0.32 seconds
  localparam int PROD_W = 26;   // |raw| * full scale
  localparam int SCL_W  = 28;   // signed scaled rate, Q16.16
  localparam int RATE_W = 29;   // signed corrected rate, Q16.16
  localparam int MAG_W  = 28;   // corrected rate magnitude
  localparam int M_W    = 44;   // magnitude * ticks
  localparam int PPL_W  = 48;   // low partial product
  localparam int PPH_W  = 60;   // high partial product
  localparam int SUM_W  = 76;   // full product plus rounding
  localparam int INC_W  = 45;   // signed angle increment
  localparam int ANGX_W = 25;
  localparam int ANGY_W = 32;
  localparam int ANGZ_W = 25;
  localparam int ACC_W  = 46;   // angle plus increment
  localparam int AXES   = 3;

  localparam int CFG_IDX_W = 2;

  localparam logic [FS_W-1:0] FS_RESET = 11'd2000;
  localparam logic [DB_W-1:0] DB_RESET = 8'd5;
  localparam logic [TP_W-1:0] TP_RESET = 32'd4295;

  // Divide by 32767 with rounding to nearest
  localparam logic [15:0] DIV_K   = 16'd32767;
  localparam logic [27:0] ROUND_K = 28'd16383;
  localparam logic [SUM_W-1:0] HALF_Q32 = SUM_W'(64'h8000_0000);

  localparam logic signed [ANGX_W-1:0] ANG_X_LIM = 25'sd11796480;  // 180 deg
  localparam logic [ANGZ_W-1:0]        ANG_Z_LIM = 25'd23592960;   // 360 deg

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FULL_SCALE = 2'd0,
    CFG_DEADBAND   = 2'd1,
    CFG_TICK_PER   = 2'd2
  } cfg_idx_t;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_MULFS = 9'b000000010,
    ST_SCALE = 9'b000000100,
    ST_RATE  = 9'b000001000,
    ST_MULT  = 9'b000010000,
    ST_PPLO  = 9'b000100000,
    ST_PPHI  = 9'b001000000,
    ST_INC   = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_t;

  // Step enables from the sequencer to every lane
  typedef struct packed {
    logic load;
    logic mul_fs;
    logic scale;
    logic cap;
    logic rate;
    logic mul_t;
    logic pp_lo;
    logic pp_hi;
    logic inc;
  } lane_ctl_t;

  // What one lane hands to the merging stage
  typedef struct packed {
    logic signed [RATE_W-1:0] rate;
    logic signed [INC_W-1:0]  inc;
  } lane_res_t;

endpackage

// ===== rtl/gai_lane.sv =====
// One axis lane: scale, bias removal, deadband and angle increment over sequenced steps.
module gai_lane
  import gai_pkg::*;
(
  input  logic                     clk,
  input  lane_ctl_t                ctl,
  input  logic signed [RAW_W-1:0]  raw,
  input  logic [TICK_W-1:0]        ticks,
  input  logic [FS_W-1:0]          full_scale,
  input  logic [DB_W-1:0]          deadband,
  input  logic [TP_W-1:0]          tick_period,
  output lane_res_t                res
);

  logic signed [RAW_W-1:0]  raw_r;
  logic [PROD_W-1:0]        prod_r;
  logic                     neg_r;
  logic signed [SCL_W-1:0]  scaled_r, scaled_nxt;
  logic signed [SCL_W-1:0]  bias_r;
  logic signed [RATE_W-1:0] rate_r;
  logic [MAG_W-1:0]         rmag_r;
  logic                     rneg_r;
  logic [M_W-1:0]           m_r;
  logic [PPL_W-1:0]         pl_r;
  logic [PPH_W-1:0]         ph_r;
  logic signed [INC_W-1:0]  inc_r;

  logic [RAW_W-1:0]        raw_mag;
  logic [RAW_W+FS_W-1:0]   prod_full;
  logic [PROD_W:0]         p2;
  logic [27:0]             mm;
  logic [12:0]             hi;
  logic [14:0]             lo;
  logic [15:0]             hl;
  logic [PROD_W:0]         qs;
  logic [SCL_W-1:0]        sq;
  logic signed [RATE_W-1:0] diff;
  logic [RATE_W-1:0]       dmag;
  logic [23:0]             band;
  logic                    zero_rate;
  logic [27:0]             mop;
  logic [PPH_W-1:0]        pprod;
  logic [SUM_W-1:0]        sum;
  logic [INC_W-1:0]        qi;

  // Scale: |raw| * fs * 65536 / 32767, using 2^15 = 1 modulo 32767
  assign raw_mag   = raw_r[RAW_W-1] ? RAW_W'(-raw_r) : RAW_W'(raw_r);
  assign prod_full = raw_mag * full_scale;
  assign p2        = {prod_r, 1'b0};
  assign mm        = 28'(p2) + ROUND_K;
  assign hi        = mm[27:15];
  assign lo        = mm[14:0];
  assign hl        = 16'(hi) + 16'(lo);
  assign qs        = p2 + (PROD_W+1)'(hi) + (PROD_W+1)'(hl >= DIV_K);
  assign sq        = {1'b0, qs};
  assign scaled_nxt = neg_r ? $signed(-sq) : $signed(sq);

  // Bias removal and deadband
  assign diff      = RATE_W'(scaled_r) - RATE_W'(bias_r);
  assign dmag      = diff[RATE_W-1] ? RATE_W'(-diff) : RATE_W'(diff);
  assign band      = {deadband, 16'b0};
  assign zero_rate = dmag < RATE_W'(band);

  // Shared multiplier for the two halves of m * period
  assign mop   = ctl.pp_hi ? m_r[M_W-1:16] : {12'b0, m_r[15:0]};
  assign pprod = mop * tick_period;

  // Round the Q0.32 product to nearest, halves away from zero
  assign sum = {ph_r, 16'b0} + SUM_W'(pl_r) + HALF_Q32;
  assign qi  = {1'b0, sum[SUM_W-1:32]};

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      raw_r <= raw;
    end
    if (ctl.mul_fs) begin
      prod_r <= prod_full[PROD_W-1:0];
      neg_r  <= raw_r[RAW_W-1];
    end
    if (ctl.scale) begin
      scaled_r <= scaled_nxt;
    end
    if (ctl.cap) begin
      bias_r <= scaled_nxt;
    end
    if (ctl.rate) begin
      rate_r <= zero_rate ? '0 : diff;
      rmag_r <= zero_rate ? '0 : dmag[MAG_W-1:0];
      rneg_r <= diff[RATE_W-1];
    end
    if (ctl.mul_t) begin
      m_r <= rmag_r * ticks;
    end
    if (ctl.pp_lo) begin
      pl_r <= pprod[PPL_W-1:0];
    end
    if (ctl.pp_hi) begin
      ph_r <= pprod;
    end
    if (ctl.inc) begin
      inc_r <= rneg_r ? $signed(-qi) : $signed(qi);
    end
  end

  assign res.rate = rate_r;
  assign res.inc  = inc_r;

endmodule

// ===== rtl/gai_merge.sv =====
// Merging stage: angle accumulators with per-axis wrap or clamp, and the result register.
module gai_merge
  import gai_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      commit,
  input  lane_res_t                 res [AXES],
  input  logic                      take,
  output logic                      free,
  output logic                      valid,
  output logic signed [RATE_W-1:0]  rate_o [AXES],
  output logic signed [ANGX_W-1:0]  angle_x,
  output logic signed [ANGY_W-1:0]  angle_y,
  output logic [ANGZ_W-1:0]         angle_z
);

  localparam logic signed [ACC_W-1:0] X_HI = ACC_W'(ANG_X_LIM);
  localparam logic signed [ACC_W-1:0] X_LO = -X_HI;
  localparam logic signed [ACC_W-1:0] Z_HI = ACC_W'(ANG_Z_LIM);
  localparam logic signed [ACC_W-1:0] Y_HI = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] Y_LO = -Y_HI;

  logic signed [ANGX_W-1:0] angx_r, angx_nxt;
  logic signed [ANGY_W-1:0] angy_r, angy_nxt;
  logic [ANGZ_W-1:0]        angz_r, angz_nxt;
  logic                     valid_r;
  logic signed [RATE_W-1:0] rate_r [AXES];

  logic signed [ACC_W-1:0] ax, ay, az;

  assign ax = ACC_W'(angx_r) + ACC_W'(res[0].inc);
  assign ay = ACC_W'(angy_r) + ACC_W'(res[1].inc);
  assign az = $signed(ACC_W'(angz_r)) + ACC_W'(res[2].inc);

  always_comb begin
    // X jumps to the opposite end
    if (ax > X_HI) begin
      angx_nxt = -ANG_X_LIM;
    end else if (ax < X_LO) begin
      angx_nxt = ANG_X_LIM;
    end else begin
      angx_nxt = ax[ANGX_W-1:0];
    end
    // Y clamps
    if (ay > Y_HI) begin
      angy_nxt = Y_HI[ANGY_W-1:0];
    end else if (ay < Y_LO) begin
      angy_nxt = Y_LO[ANGY_W-1:0];
    end else begin
      angy_nxt = ay[ANGY_W-1:0];
    end
    // Z wraps within one turn
    if (az > Z_HI) begin
      angz_nxt = '0;
    end else if (az < 0) begin
      angz_nxt = ANG_Z_LIM;
    end else begin
      angz_nxt = az[ANGZ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angx_r  <= '0;
      angy_r  <= '0;
      angz_r  <= '0;
      valid_r <= 1'b0;
    end else if (commit) begin
      angx_r  <= angx_nxt;
      angy_r  <= angy_nxt;
      angz_r  <= angz_nxt;
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      for (int i = 0; i < AXES; i++) begin
        rate_r[i] <= res[i].rate;
      end
    end
  end

  assign free    = !valid_r || take;
  assign valid   = valid_r;
  assign rate_o  = rate_r;
  assign angle_x = angx_r;
  assign angle_y = angy_r;
  assign angle_z = angz_r;

endmodule

// ===== rtl/gyro_angle_integrator_unit.sv =====
// Top level of the gyro angle integrator: config registers, sequencer, three lanes, merge.
//
// Input beats on in_* carry one three-axis raw gyro sample plus the timer ticks
// since the previous one. Result beats on out_* carry the bias-corrected,
// deadbanded rates (Q16.16 deg/s) and the three integrated angles (Q16.16 deg).
// Exactly one result beat follows every input beat, in order.
// The cfg_* port writes full scale, deadband and tick period; write it only
// while no beat is in flight. Index 3 is ignored.
// Flow control: in_tready is high only while the sequencer idles. After an
// accepted beat the three lanes step together through eight sequencer states,
// the last of which commits the result to the output register, so a new beat
// is taken only once the previous one has left the sequencer. The length is
// set by each lane's multiply chain: the full-scale multiply, then |rate| *
// ticks, then two halves of the period multiply through one shared multiplier.
// Reset (rst_n low, synchronous) restores the register defaults, clears the
// angles to zero and forgets the bias; the next sample becomes the new bias.
// When the receiver stalls, the finished result holds in the output register
// and the sequencer waits in its last state until the slot frees up.
module gyro_angle_integrator_unit
  import gai_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // Input stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [63:0]          in_tdata,   // raw_x[15:0] raw_y[31:16] raw_z[47:32]
                                           // elapsed_ticks[63:48]
  // Result stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [175:0]         out_tdata,  // rate_x[28:0] rate_y[57:29] rate_z[86:58]
                                           // angle_x[111:87] angle_y[143:112]
                                           // angle_z[168:144], zero pad above
  // Configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [TP_W-1:0]      cfg_wdata
);

  state_t               state_r, state_nxt;
  logic                 captured_r;
  logic [TICK_W-1:0]    ticks_r;
  logic [FS_W-1:0]      fs_r;
  logic [DB_W-1:0]      db_r;
  logic [TP_W-1:0]      tp_r;

  logic                     in_acc;
  logic                     commit;
  logic                     merge_free;
  lane_ctl_t                ctl;
  lane_res_t                res [AXES];
  logic signed [RAW_W-1:0]  raw [AXES];
  logic signed [RATE_W-1:0] rate_o [AXES];
  logic signed [ANGX_W-1:0] angle_x;
  logic signed [ANGY_W-1:0] angle_y;
  logic [ANGZ_W-1:0]        angle_z;

  // Hold tready low while reset is applied
  assign in_tready = rst_n && (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign commit    = (state_r == ST_DONE) && merge_free;

  assign raw[0] = $signed(in_tdata[15:0]);
  assign raw[1] = $signed(in_tdata[31:16]);
  assign raw[2] = $signed(in_tdata[47:32]);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r <= FS_RESET;
      db_r <= DB_RESET;
      tp_r <= TP_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_FULL_SCALE: fs_r <= cfg_wdata[FS_W-1:0];
        CFG_DEADBAND:   db_r <= cfg_wdata[DB_W-1:0];
        CFG_TICK_PER:   tp_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer: wait in IDLE for a beat, then advance one step a cycle, hold in DONE while the output is full
  always_comb begin
    case (state_r)
      ST_IDLE:  state_nxt = in_acc ? ST_MULFS : ST_IDLE;
      ST_MULFS: state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_RATE;
      ST_RATE:  state_nxt = ST_MULT;
      ST_MULT:  state_nxt = ST_PPLO;
      ST_PPLO:  state_nxt = ST_PPHI;
      ST_PPHI:  state_nxt = ST_INC;
      ST_INC:   state_nxt = ST_DONE;
      ST_DONE:  state_nxt = merge_free ? ST_IDLE : ST_DONE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      captured_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_SCALE) begin
        captured_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ticks_r <= in_tdata[63:48];
    end
  end

  assign ctl.load   = in_acc;
  assign ctl.mul_fs = (state_r == ST_MULFS);
  assign ctl.scale  = (state_r == ST_SCALE);
  assign ctl.cap    = (state_r == ST_SCALE) && !captured_r;
  assign ctl.rate   = (state_r == ST_RATE);
  assign ctl.mul_t  = (state_r == ST_MULT);
  assign ctl.pp_lo  = (state_r == ST_PPLO);
  assign ctl.pp_hi  = (state_r == ST_PPHI);
  assign ctl.inc    = (state_r == ST_INC);

  for (genvar g = 0; g < AXES; g++) begin : g_lane
    gai_lane u_lane (
      .clk         (clk),
      .ctl         (ctl),
      .raw         (raw[g]),
      .ticks       (ticks_r),
      .full_scale  (fs_r),
      .deadband    (db_r),
      .tick_period (tp_r),
      .res         (res[g])
    );
  end

  gai_merge u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .commit  (commit),
    .res     (res),
    .take    (out_tready),
    .free    (merge_free),
    .valid   (out_tvalid),
    .rate_o  (rate_o),
    .angle_x (angle_x),
    .angle_y (angle_y),
    .angle_z (angle_z)
  );

  assign out_tdata = {7'b0, angle_z, angle_y, angle_x, rate_o[2], rate_o[1], rate_o[0]};

  // The wrapped X angle never leaves +-180 deg
  a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[111:87]) <= ANG_X_LIM &&
                    $signed(out_tdata[111:87]) >= -ANG_X_LIM))
    else $error("angle_x out of range");

  // The wrapped Z angle never exceeds one turn
  a_z_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[168:144] <= ANG_Z_LIM))
    else $error("angle_z out of range");

  // Any result implies the bias has been captured
  a_bias: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> captured_r)
    else $error("result without captured bias");

  // A full output slot holds the sequencer in its last state
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_tvalid && !out_tready) |=> state_r == ST_DONE)
    else $error("result committed over a pending beat");

endmodule

// ===== tb/gyro_angle_integrator_unit_tb.sv =====
// Self-checking testbench for the gyro angle integrator: stream stimulus, predictor, scoreboard.
`timescale 1ns / 1ps

module gyro_angle_integrator_unit_tb;
  import gai_pkg::*;

  // Register index outside the register map; writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // Raw counts of the first sample, which the block keeps as its bias
  localparam int BIAS_X = 100;
  localparam int BIAS_Y = -200;
  localparam int BIAS_Z = 50;

  localparam longint DEG       = 65536;
  localparam longint X_WRAP    = 180 * DEG;
  localparam longint Z_WRAP    = 360 * DEG;
  localparam longint Y_SAT     = 64'sd2147483647;
  localparam int     SETTLE    = 12;    // idle cycles after the last result is back
  localparam int     IDLE_LIMIT = 5000; // cycles without any beat before giving up
  localparam int     PHASES    = 6;
  localparam int     PHASE_LEN = 117;

  // One input beat, lowest field in the lowest bits (matches in_tdata)
  typedef struct packed {
    logic [TICK_W-1:0]        ticks;
    logic signed [RAW_W-1:0]  raw_z;
    logic signed [RAW_W-1:0]  raw_y;
    logic signed [RAW_W-1:0]  raw_x;
  } gyro_sample_t;

  // One result beat, lowest field in the lowest bits (matches out_tdata)
  typedef struct packed {
    logic [6:0]                pad;
    logic [ANGZ_W-1:0]         angle_z;
    logic signed [ANGY_W-1:0]  angle_y;
    logic signed [ANGX_W-1:0]  angle_x;
    logic signed [RATE_W-1:0]  rate_z;
    logic signed [RATE_W-1:0]  rate_y;
    logic signed [RATE_W-1:0]  rate_x;
  } attitude_t;

  // Tracks registers, bias and angles; predicts each result and checks it in order
  class attitude_scoreboard;
    logic [FS_W-1:0] full_scale;
    logic [DB_W-1:0] deadband;
    logic [TP_W-1:0] tick_period;
    bit              have_bias;
    longint          bias_rate[3];
    longint          angle[3];
    attitude_t       expected_q[$];
    int              mismatches;

    function new();
      full_scale  = FS_RESET;
      deadband    = DB_RESET;
      tick_period = TP_RESET;
      have_bias   = 1'b0;
      mismatches  = 0;
      for (int i = 0; i < 3; i++) begin
        bias_rate[i] = 0;
        angle[i]     = 0;
      end
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [TP_W-1:0] value);
      case (idx)
        CFG_FULL_SCALE: full_scale  = value[FS_W-1:0];
        CFG_DEADBAND:   deadband    = value[DB_W-1:0];
        CFG_TICK_PER:   tick_period = value;
        default: ;
      endcase
    endfunction

    // raw * full scale / 32767 in Q16.16, halves away from zero
    function longint scale_rate(logic signed [RAW_W-1:0] raw);
      longint          r;
      longint unsigned mag;
      longint unsigned q;
      r   = raw;
      mag = (r < 0) ? -r : r;
      q   = (mag * 64'(full_scale) * 64'd65536 + 64'd16383) / 64'd32767;
      return (r < 0) ? -longint'(q) : longint'(q);
    endfunction

    // rate * ticks * period / 2^32, halves away from zero
    function longint angle_increment(longint rate, logic [TICK_W-1:0] ticks);
      logic [127:0]    prod;
      longint unsigned mag;
      mag  = (rate < 0) ? -rate : rate;
      prod = 128'(mag) * 128'(ticks) * 128'(tick_period) + 128'h8000_0000;
      return (rate < 0) ? -longint'(prod[95:32]) : longint'(prod[95:32]);
    endfunction

    function void note_sample(gyro_sample_t s);
      logic signed [RAW_W-1:0] raw[3];
      longint    scaled[3];
      longint    rate[3];
      longint    r;
      longint    band;
      longint    nxt;
      attitude_t want;
      raw[0] = s.raw_x;
      raw[1] = s.raw_y;
      raw[2] = s.raw_z;
      band   = longint'(deadband) * DEG;
      for (int i = 0; i < 3; i++) scaled[i] = scale_rate(raw[i]);
      // the first sample after reset becomes the bias, at the scale then in force
      if (!have_bias) begin
        for (int i = 0; i < 3; i++) bias_rate[i] = scaled[i];
        have_bias = 1'b1;
      end
      for (int i = 0; i < 3; i++) begin
        r       = scaled[i] - bias_rate[i];
        rate[i] = (((r < 0) ? -r : r) < band) ? 0 : r;
      end
      // X jumps to the opposite end past +-180
      nxt = angle[0] + angle_increment(rate[0], s.ticks);
      if (nxt > X_WRAP) nxt = -X_WRAP;
      else if (nxt < -X_WRAP) nxt = X_WRAP;
      angle[0] = nxt;
      // Y clamps
      nxt = angle[1] + angle_increment(rate[1], s.ticks);
      if (nxt > Y_SAT) nxt = Y_SAT;
      else if (nxt < -Y_SAT) nxt = -Y_SAT;
      angle[1] = nxt;
      // Z jumps to the opposite end outside 0..360
      nxt = angle[2] + angle_increment(rate[2], s.ticks);
      if (nxt > Z_WRAP) nxt = 0;
      else if (nxt < 0) nxt = Z_WRAP;
      angle[2] = nxt;

      want.pad     = '0;
      want.rate_x  = RATE_W'(rate[0]);
      want.rate_y  = RATE_W'(rate[1]);
      want.rate_z  = RATE_W'(rate[2]);
      want.angle_x = ANGX_W'(angle[0]);
      want.angle_y = ANGY_W'(angle[1]);
      want.angle_z = ANGZ_W'(angle[2]);
      expected_q.push_back(want);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string what);
      if (mismatches < 100) $display("[%0t] MISMATCH: %s", $time, what);
      mismatches++;
    endtask

    task compare_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
        report($sformatf("%s got %h expected %h", name, got, want));
    endtask

    task check_result(attitude_t got);
      attitude_t want;
      if (expected_q.size() == 0) begin
        report("result beat with no sample outstanding");
        return;
      end
      want = expected_q.pop_front();
      compare_field("rate_x",  64'(got.rate_x),  64'(want.rate_x));
      compare_field("rate_y",  64'(got.rate_y),  64'(want.rate_y));
      compare_field("rate_z",  64'(got.rate_z),  64'(want.rate_z));
      compare_field("angle_x", 64'(got.angle_x), 64'(want.angle_x));
      compare_field("angle_y", 64'(got.angle_y), 64'(want.angle_y));
      compare_field("angle_z", 64'(got.angle_z), 64'(want.angle_z));
      compare_field("pad",     64'(got.pad),     64'(want.pad));
    endtask
  endclass

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [63:0]          in_tdata   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [175:0]         out_tdata;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr   = '0;
  logic [TP_W-1:0]      cfg_wdata  = '0;

  int send_idle_pct  = 16;
  int recv_stall_pct = 58;
  int idle_cycles    = 0;

  attitude_scoreboard sb;

  gyro_angle_integrator_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: drop tready at random at the configured stall rate
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Monitors: every accepted input beat feeds the predictor, every result beat is checked.
  // Values read here are the ones present at the edge, since everything updates by NBA.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_sample(gyro_sample_t'(in_tdata));
    if (rst_n && out_tvalid && out_tready) sb.check_result(attitude_t'(out_tdata));
  end

  // Watchdog: end the run if neither side moves a beat for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic gyro_sample_t sample_of(int x, int y, int z, int t);
    gyro_sample_t s;
    s.raw_x = x[RAW_W-1:0];
    s.raw_y = y[RAW_W-1:0];
    s.raw_z = z[RAW_W-1:0];
    s.ticks = t[TICK_W-1:0];
    return s;
  endfunction

  // Mostly small motion around the bias, some full-range noise, rail values and values near zero
  function automatic int pick_raw(int center);
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 12) return center + int'($urandom_range(0, 800)) - 400;
    if (roll < 17) return $urandom_range(0, 65535) - 32768;
    if (roll == 17) return -32768;
    if (roll == 18) return 32767;
    return $urandom_range(0, 1) ? 0 : -1;
  endfunction

  function automatic int pick_ticks();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 0;
    if (roll == 1) return 65535;
    if (roll < 7) return $urandom_range(1, 2000);
    return $urandom_range(0, 65535);
  endfunction

  // Hold the beat until accepted; leaves tvalid high on return
  task automatic send_sample(gyro_sample_t s);
    int gap;
    gap = 0;
    while (gap < 24 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stop sending, wait for every outstanding result, then let the pipeline settle.
  // Step one edge first so the monitor has noted the last accepted beat.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TP_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    sb.set_reg(idx, value);
    @(posedge clk);
  endtask

  // Rewrite all registers while the block is idle; optionally poke the unused index too
  task automatic reprogram(logic [TP_W-1:0] fs_word, logic [TP_W-1:0] db_word,
                           logic [TP_W-1:0] tp_word, bit poke_unused);
    wait_drained();
    write_reg(CFG_FULL_SCALE, fs_word);
    write_reg(CFG_DEADBAND, db_word);
    write_reg(CFG_TICK_PER, tp_word);
    if (poke_unused) write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [TP_W-1:0] fs_word;
    logic [TP_W-1:0] db_word;
    logic [TP_W-1:0] tp_word;

    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset registers: 2000 dps full scale, 5 dps deadband, 1 us ticks.
    // First beat is captured as the bias, so its own rates come out zero.
    send_sample(sample_of(BIAS_X, BIAS_Y, BIAS_Z, 65535));
    // Just inside and just outside the deadband, both signs
    send_sample(sample_of(BIAS_X + 81, BIAS_Y - 81, BIAS_Z + 82, 1000));
    send_sample(sample_of(BIAS_X - 82, BIAS_Y + 82, BIAS_Z - 81, 1000));
    // Full-rail rates with zero elapsed ticks: angles hold
    send_sample(sample_of(32767, -32768, 32767, 0));
    // Spin up: X passes +180, Z passes 360, Y runs negative
    repeat (3) send_sample(sample_of(32767, -32768, 32767, 65535));
    // Spin back: X passes -180, Z drops below 0
    repeat (2) send_sample(sample_of(-32768, 32767, -32768, 65535));

    // Full scale above 2000 with the bias still at the old scale, no deadband,
    // longest tick period: Y saturates both ways
    reprogram(32'd2047, 32'd0, 32'hFFFF_FFFF, 1'b0);
    send_sample(sample_of(BIAS_X, BIAS_Y, BIAS_Z, 1));
    send_sample(sample_of(1, 32767, 1, 65535));
    send_sample(sample_of(1, -32768, 1, 65535));
    send_sample(sample_of(-1, -1, 0, 65535));

    // Zero tick period: angles hold
    reprogram(32'd1500, 32'd40, 32'd0, 1'b0);
    send_sample(sample_of(32767, 32767, -32768, 65535));

    // Zero full scale (high bits set and ignored), widest deadband, shortest period,
    // plus a write to the unused index that must change nothing
    reprogram(32'hFFFF_F800, 32'hFFFF_FFFF, 32'd1, 1'b1);
    send_sample(sample_of(-32768, 32767, 12345, 65535));

    // Lowest nominal full scale
    reprogram(32'd250, 32'd0, 32'd4295, 1'b0);
    send_sample(sample_of(-32768, 32767, -32768, 65535));
    send_sample(sample_of(BIAS_X, BIAS_Y, BIAS_Z, 0));

    // Random phases: receiver-heavy stalling, then sender-heavy idling, then none
    for (int phase = 0; phase < PHASES; phase++) begin
      send_idle_pct  = (phase < 2) ? 16 : (phase < 4) ? 58 : 0;
      recv_stall_pct = (phase < 2) ? 58 : (phase < 4) ? 16 : 0;
      case (phase)
        0: begin
          fs_word = 32'd250;  db_word = 32'd0;   tp_word = 32'd4295;
        end
        1: begin
          fs_word = 32'd2000; db_word = 32'd255; tp_word = 32'hFFFF_FFFF;
        end
        2: begin
          fs_word = 32'd2047; db_word = 32'd5;   tp_word = 32'd1;
        end
        default: begin
          fs_word = $urandom_range(250, 2000);
          db_word = $urandom_range(0, 255);
          tp_word = $urandom_range(0, 1) ? $urandom : $urandom_range(1000, 100000);
        end
      endcase
      reprogram(fs_word, db_word, tp_word, 1'b0);
      for (int n = 0; n < PHASE_LEN; n++) begin
        // hold off now and then until every result is back
        if (n > 0 && n % 40 == 0) wait_drained();
        send_sample(sample_of(pick_raw(BIAS_X), pick_raw(BIAS_Y), pick_raw(BIAS_Z),
                              pick_ticks()));
      end
    end

    wait_drained();
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
